### src/tlpt_pkg.sv
package tlpt_pkg;

    localparam int DIR_ENTRIES   = 1024;
    localparam int TABLE_ENTRIES = 1024;
    localparam int NUM_TABLES    = 4;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int TBL_W   = $clog2(NUM_TABLES);
    localparam int POOL_N  = NUM_TABLES * TABLE_ENTRIES;
    localparam int POOL_AW = $clog2(POOL_N);

    localparam int DIR_SHIFT = 22;
    localparam int PG_SHIFT  = 12;
    localparam int OFS_W     = 12;

    localparam logic [31:0] FB_BASE   = 32'hFD000000;
    localparam logic [31:0] HEAP_BASE = 32'hE0000000;

    localparam logic [IDX_W-1:0] DIR_IDX_IDENT = '0;
    localparam logic [IDX_W-1:0] DIR_IDX_FB    = FB_BASE[31:DIR_SHIFT];
    localparam logic [IDX_W-1:0] DIR_IDX_HEAP  = HEAP_BASE[31:DIR_SHIFT];

    localparam logic [TBL_W-1:0] TBL_IDENT = TBL_W'(0);
    localparam logic [TBL_W-1:0] TBL_FB    = TBL_W'(1);
    localparam logic [TBL_W-1:0] TBL_HEAP  = TBL_W'(2);

    localparam logic [OFS_W-1:0] PTE_PRESENT  = 12'h001;
    localparam logic [OFS_W-1:0] PTE_BOOT_FLG = 12'h003;

    typedef enum logic [1:0] {
        REQ_MAP   = 2'd0,
        REQ_UNMAP = 2'd1,
        REQ_XLATE = 2'd2,
        REQ_RSVD  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE        = 2'd0,
        ST_DIR_ABSENT  = 2'd1,
        ST_PAGE_ABSENT = 2'd2
    } t_status;

    typedef struct packed {
        logic             present;
        logic [TBL_W-1:0] tbl;
    } t_dir_entry;

    typedef struct packed {
        logic init_wr;
        logic accept;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic init_last;
    } t_sts;

    // directory is fixed by the boot map
    function automatic t_dir_entry dir_lookup(input logic [IDX_W-1:0] di);
        t_dir_entry e;
        e.present = 1'b0;
        e.tbl     = '0;
        case (di)
            DIR_IDX_IDENT: begin
                e.present = 1'b1;
                e.tbl     = TBL_IDENT;
            end
            DIR_IDX_FB: begin
                e.present = 1'b1;
                e.tbl     = TBL_FB;
            end
            DIR_IDX_HEAP: begin
                e.present = 1'b1;
                e.tbl     = TBL_HEAP;
            end
            default: begin
                e.present = 1'b0;
                e.tbl     = '0;
            end
        endcase
        return e;
    endfunction

    function automatic logic [31:0] boot_pte(input logic [POOL_AW-1:0] addr);
        logic [TBL_W-1:0] t;
        logic [IDX_W-1:0] i;
        logic [31:0]      pte;
        t   = addr[POOL_AW-1:IDX_W];
        i   = addr[IDX_W-1:0];
        pte = '0;
        case (t)
            TBL_IDENT: pte = {{(32-IDX_W-PG_SHIFT){1'b0}}, i, PTE_BOOT_FLG};
            TBL_FB:    pte = FB_BASE | {{(32-IDX_W-PG_SHIFT){1'b0}}, i, PTE_BOOT_FLG};
            default:   pte = '0;
        endcase
        return pte;
    endfunction

endpackage

### src/two_level_page_table_engine_top.sv
// Two-level page table engine. Each request (map, unmap, translate) yields one
// response: map and unmap take the request and write the page-table entry in the
// acceptance cycle; translate reads the entry then and builds the address from the
// registered read data in the response state. The directory lookup is combinational
// and addresses the registered read of the single-port page-table memory; the
// engine takes no new request until the last response is loaded into its output
// register, where it waits, and the next request is taken while it waits.
// After reset the engine loads the boot map into the 4096-entry table memory, one
// entry per cycle, and takes no request until all are written. The directory is
// fixed by the boot map: entries 0, 896 and 1012.
module two_level_page_table_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_phys_addr,
    input  logic [11:0] i_page_flags,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_phys_result
);
    import tlpt_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    tlpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    tlpt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_req_type    (i_req_type),
        .i_virt_addr   (i_virt_addr),
        .i_phys_addr   (i_phys_addr),
        .i_page_flags  (i_page_flags),
        .o_status      (o_status),
        .o_phys_result (o_phys_result)
    );

endmodule

### src/tlpt_ctrl.sv
module tlpt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  tlpt_pkg::t_sts i_sts,
    output tlpt_pkg::t_cmd o_cmd
);
    import tlpt_pkg::*;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_ready;
        o_cmd        = '0;
        o_ready      = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

### src/tlpt_dp.sv
module tlpt_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tlpt_pkg::t_cmd i_cmd,
    output tlpt_pkg::t_sts o_sts,
    input  logic [1:0]     i_req_type,
    input  logic [31:0]    i_virt_addr,
    input  logic [31:0]    i_phys_addr,
    input  logic [11:0]    i_page_flags,
    output logic [1:0]     o_status,
    output logic [31:0]    o_phys_result
);
    import tlpt_pkg::*;

    logic [31:0] r_pool [POOL_N];

    logic [POOL_AW-1:0] r_init_addr;
    logic [31:0]        r_rd_data;
    t_req               r_kind;
    logic               r_dir_hit;
    logic [OFS_W-1:0]   r_offset;
    logic [1:0]         r_status;
    logic [31:0]        r_result;

    t_req               w_kind;
    t_dir_entry         w_dir;
    logic [POOL_AW-1:0] w_req_addr;
    logic [POOL_AW-1:0] w_mem_addr;
    logic [31:0]        w_mem_wd;
    logic               w_mem_we;
    logic               w_mem_re;
    logic [1:0]         n_status;
    logic [31:0]        n_result;

    assign w_kind     = t_req'(i_req_type);
    assign w_dir      = dir_lookup(i_virt_addr[31:DIR_SHIFT]);
    assign w_req_addr = {w_dir.tbl, i_virt_addr[PG_SHIFT+IDX_W-1:PG_SHIFT]};

    always_comb begin
        w_mem_we   = 1'b0;
        w_mem_re   = 1'b0;
        w_mem_addr = w_req_addr;
        w_mem_wd   = '0;
        if (i_cmd.init_wr) begin
            w_mem_we   = 1'b1;
            w_mem_addr = r_init_addr;
            w_mem_wd   = boot_pte(r_init_addr);
        end else if (i_cmd.accept && w_dir.present) begin
            case (w_kind)
                REQ_MAP: begin
                    w_mem_we = 1'b1;
                    w_mem_wd = {i_phys_addr[31:PG_SHIFT], i_page_flags | PTE_PRESENT};
                end
                REQ_UNMAP: begin
                    w_mem_we = 1'b1;
                    w_mem_wd = '0;
                end
                REQ_XLATE: begin
                    w_mem_re = 1'b1;
                end
                default: begin
                    w_mem_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_pool[w_mem_addr] <= w_mem_wd;
        end
        if (w_mem_re) begin
            r_rd_data <= r_pool[w_mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_addr <= '0;
        end else if (i_cmd.init_wr) begin
            r_init_addr <= r_init_addr + POOL_AW'(1);
        end
    end

    assign o_sts.init_last = (r_init_addr == POOL_AW'(POOL_N - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind    <= w_kind;
            r_dir_hit <= w_dir.present;
            r_offset  <= i_virt_addr[OFS_W-1:0];
        end
    end

    always_comb begin
        n_status = ST_DONE;
        n_result = '0;
        if (r_kind != REQ_RSVD && !r_dir_hit) begin
            n_status = ST_DIR_ABSENT;
        end else if (r_kind == REQ_XLATE) begin
            if (!r_rd_data[0]) begin
                n_status = ST_PAGE_ABSENT;
            end else begin
                n_result = {r_rd_data[31:PG_SHIFT], r_offset};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status <= n_status;
            r_result <= n_result;
        end
    end

    assign o_status      = r_status;
    assign o_phys_result = r_result;

endmodule

### tb/tb_two_level_page_table_engine_top.sv
module tb_two_level_page_table_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tlpt_pkg::*;

    localparam int PTE_DEPTH = NUM_TABLES * TABLE_ENTRIES;
    localparam logic [9:0] DIR_LOW  = 10'd0;
    localparam logic [9:0] DIR_HEAP = HEAP_BASE[31:22];
    localparam logic [9:0] DIR_FB   = FB_BASE[31:22];

    typedef struct {
        t_status     st;
        logic [31:0] pa;
    } t_xlate_rsp;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [1:0]  i_req_type   = 2'd0;
    logic [31:0] i_virt_addr  = 32'd0;
    logic [31:0] i_phys_addr  = 32'd0;
    logic [11:0] i_page_flags = 12'd0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [31:0] o_phys_result;

    logic [31:0] pte_model [0:PTE_DEPTH-1];
    t_xlate_rsp  rsp_q [$];
    int          err_count     = 0;
    int          snd_idle_pct  = 0;
    int          rcv_stall_pct = 0;

    two_level_page_table_engine_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_virt_addr   (i_virt_addr),
        .i_phys_addr   (i_phys_addr),
        .i_page_flags  (i_page_flags),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_phys_result (o_phys_result)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    function automatic bit dir_hit(input logic [9:0] di, output logic [1:0] tbl);
        tbl = 2'd0;
        case (di)
            DIR_LOW:  tbl = 2'd0;
            DIR_FB:   tbl = 2'd1;
            DIR_HEAP: tbl = 2'd2;
            default:  return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void walk_tables(input t_req kind, input logic [31:0] va,
                                        input logic [31:0] pa, input logic [11:0] fl,
                                        output t_xlate_rsp rsp);
        logic [1:0]  tbl;
        logic [11:0] pos;
        logic [31:0] pte;
        rsp.st = ST_DONE;
        rsp.pa = 32'd0;
        if (kind == REQ_RSVD) return;
        if (!dir_hit(va[31:22], tbl)) begin
            rsp.st = ST_DIR_ABSENT;
            return;
        end
        pos = {tbl, va[21:12]};
        case (kind)
            REQ_MAP:   pte_model[pos] = {pa[31:12], fl | 12'h001};
            REQ_UNMAP: pte_model[pos] = 32'd0;
            REQ_XLATE: begin
                pte = pte_model[pos];
                if (!pte[0]) rsp.st = ST_PAGE_ABSENT;
                else         rsp.pa = {pte[31:12], va[11:0]};
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: MISMATCH %s: got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    task automatic send_req(input t_req kind, input logic [31:0] va,
                            input logic [31:0] pa, input logic [11:0] fl);
        t_xlate_rsp rsp;
        while ($urandom_range(99) < snd_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_req_type   <= kind;
        i_virt_addr  <= va;
        i_phys_addr  <= pa;
        i_page_flags <= fl;
        do @(posedge i_clk); while (!o_ready);
        walk_tables(kind, va, pa, fl, rsp);
        rsp_q.push_back(rsp);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (rsp_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_xlate_rsp exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (rsp_q.size() == 0) begin
                report_mismatch("unexpected transaction", {30'd0, o_status}, 32'd0);
            end else begin
                exp_r = rsp_q.pop_front();
                if (o_status !== exp_r.st)
                    report_mismatch("status", {30'd0, o_status}, {30'd0, exp_r.st});
                if (o_phys_result !== exp_r.pa)
                    report_mismatch("phys_result", o_phys_result, exp_r.pa);
            end
        end
    end

    task automatic test_boot_map();
        send_req(REQ_XLATE, 32'h0000_0000, 32'd0, 12'd0);
        send_req(REQ_XLATE, 32'h003F_FFFF, 32'd0, 12'd0);
        send_req(REQ_XLATE, 32'hFD00_0123, 32'd0, 12'd0);
        send_req(REQ_XLATE, 32'hFD3F_FABC, 32'd0, 12'd0);
        send_req(REQ_XLATE, 32'hE000_0000, 32'd0, 12'd0);
        send_req(REQ_XLATE, 32'hE03F_FFFF, 32'd0, 12'd0);
    endtask

    task automatic test_map_unmap();
        send_req(REQ_MAP,   32'hE000_0000, 32'hFFFF_FFFF, 12'hFFF);
        send_req(REQ_XLATE, 32'hE000_0ABC, 32'd0, 12'd0);
        send_req(REQ_MAP,   32'hE03F_F000, 32'h0000_0000, 12'h000);
        send_req(REQ_XLATE, 32'hE03F_FFFF, 32'd0, 12'd0);
        send_req(REQ_UNMAP, 32'hE03F_F000, 32'hFFFF_FFFF, 12'hFFF);
        send_req(REQ_XLATE, 32'hE03F_F800, 32'd0, 12'd0);
        send_req(REQ_MAP,   32'h0000_1000, 32'h1234_5678, 12'hFFE);
        send_req(REQ_XLATE, 32'h0000_1FED, 32'd0, 12'd0);
        send_req(REQ_UNMAP, 32'hFD00_1000, 32'd0, 12'd0);
        send_req(REQ_XLATE, 32'hFD00_1234, 32'd0, 12'd0);
    endtask

    task automatic test_dir_absent();
        send_req(REQ_MAP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        send_req(REQ_UNMAP, 32'h8000_0000, 32'd0, 12'd0);
        send_req(REQ_XLATE, 32'h0040_0000, 32'd0, 12'd0);
        send_req(REQ_XLATE, 32'hFFFF_FFFF, 32'd0, 12'd0);
    endtask

    task automatic test_reserved();
        send_req(REQ_RSVD,  32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        send_req(REQ_RSVD,  32'hFFFF_FFFF, 32'h0000_0000, 12'h000);
        send_req(REQ_XLATE, 32'h0000_0000, 32'd0, 12'd0);
    endtask

    task automatic test_random_traffic(input int n, input int snd_pct, input int rcv_pct,
                                       input bit mid_pause);
        int          sel;
        t_req        kind;
        logic [9:0]  di;
        logic [31:0] va;
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        for (int k = 0; k < n; k++) begin
            if (mid_pause && k == n / 2) wait_drain();
            sel = $urandom_range(99);
            if (sel < 40)      kind = REQ_MAP;
            else if (sel < 55) kind = REQ_UNMAP;
            else if (sel < 95) kind = REQ_XLATE;
            else               kind = REQ_RSVD;
            if ($urandom_range(99) < 85) begin
                case ($urandom_range(2))
                    0:       di = DIR_LOW;
                    1:       di = DIR_HEAP;
                    default: di = DIR_FB;
                endcase
                va = $urandom();
                va[31:22] = di;
                if ($urandom_range(99) < 70) va[21:12] = 10'($urandom_range(15));
            end else begin
                va = $urandom();
            end
            send_req(kind, va, $urandom(), 12'($urandom()));
        end
        wait_drain();
    endtask

    initial begin
        for (int i = 0; i < PTE_DEPTH; i++) pte_model[i] = 32'd0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            pte_model[i]                 = {10'd0, 10'(i), 12'h003};
            pte_model[TABLE_ENTRIES + i] = FB_BASE | {10'd0, 10'(i), 12'h003};
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_boot_map();
        test_map_unmap();
        test_dir_absent();
        test_reserved();
        test_random_traffic(200, 0, 0, 1'b0);
        test_random_traffic(190, 64, 0, 1'b1);
        test_random_traffic(190, 0, 64, 1'b0);
        test_random_traffic(190, 29, 29, 1'b0);

        wait_drain();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("two_level_page_table_engine_top verification clean");
        end else begin
            $display("two_level_page_table_engine_top verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("two_level_page_table_engine_top verification failed");
        $finish;
    end

endmodule
